@@ sv/kss_pkg.sv @@
// ----------------------------------------------------------------------------
// kss_pkg
// Shared types and constants for the rank selection block.
// ----------------------------------------------------------------------------
`default_nettype none
package kss_pkg;
  localparam int MAX_ELEMENTS = 64;
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = AW + 1;
  localparam int DW = 32;
  localparam int RW = 7;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CAND,
    S_CWAIT,
    S_SCAN,
    S_DRAIN,
    S_CHECK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic cand_rd;
    logic cand_cap;
    logic scan_rd;
    logic check;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic rank_bad;
    logic scan_end;
    logic hit;
  } stat_t;
endpackage
`default_nettype wire

@@ sv/kth_smallest_select.sv @@
// ----------------------------------------------------------------------------
// kth_smallest_select
// Loads a set of signed values and returns the k-th smallest one.
// ----------------------------------------------------------------------------
// Loading takes one item per cycle. After the last item, each candidate
// is read and captured, one store read port scans all n values, and the
// counts are checked; no item is taken until the result is delivered.
// A bad rank gives a result in the cycle after the last item.
// Reset empties the set and returns to loading; store contents stay.
`default_nettype none
module kth_smallest_select (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [kss_pkg::DW-1:0] in_element_value,
  input  wire logic [kss_pkg::RW-1:0]        in_rank,
  input  wire logic                          in_last_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [kss_pkg::DW-1:0]      out_selected_value,
  output logic                               out_rank_error
);
  kss_pkg::cmd_t          cmd;
  kss_pkg::stat_t         stat;
  kss_pkg::state_t        state;
  logic [kss_pkg::CW-1:0] count;

  kss_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_item (in_last_item),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .state_o      (state)
  );

  kss_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_element_value   (in_element_value),
    .in_rank            (in_rank),
    .in_last_item       (in_last_item),
    .stat               (stat),
    .out_selected_value (out_selected_value),
    .out_rank_error     (out_rank_error),
    .count_o            (count)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rank_error) |-> (out_selected_value == '0))
    else $error("error result carries a nonzero value");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count <= kss_pkg::CW'(kss_pkg::MAX_ELEMENTS)) else $error("set count overflow");

  a_empty_after: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> (count == '0 && state == kss_pkg::S_LOAD))
    else $error("set not emptied after result");
endmodule
`default_nettype wire

@@ sv/kss_ram.sv @@
// ----------------------------------------------------------------------------
// kss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module kss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/kss_datapath.sv @@
// ----------------------------------------------------------------------------
// kss_datapath
// Value store, candidate register and rank counters for selection.
// ----------------------------------------------------------------------------
`default_nettype none
module kss_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire kss_pkg::cmd_t                 cmd,
  input  wire logic signed [kss_pkg::DW-1:0] in_element_value,
  input  wire logic [kss_pkg::RW-1:0]        in_rank,
  input  wire logic                          in_last_item,
  output kss_pkg::stat_t                     stat,
  output logic signed [kss_pkg::DW-1:0]      out_selected_value,
  output logic                               out_rank_error,
  output logic [kss_pkg::CW-1:0]             count_o
);
  logic [kss_pkg::CW-1:0] count_r, count_nxt, n_now;
  logic [kss_pkg::AW-1:0] i_r, i_nxt, j_r, j_nxt, raddr;
  logic [kss_pkg::CW-1:0] lt_r, lt_nxt, le_r, le_nxt;
  logic [kss_pkg::RW-1:0] rank_r, rank_nxt;
  logic signed [kss_pkg::DW-1:0] cand_r, cand_nxt, res_r, res_nxt, rdata;
  logic err_r, err_nxt, cmp_v_r, cmp_v_nxt, room;

  assign room  = count_r < kss_pkg::CW'(kss_pkg::MAX_ELEMENTS);
  assign n_now = room ? count_r + kss_pkg::CW'(1) : count_r;
  assign raddr = cmd.cand_rd ? i_r : j_r;

  kss_ram #(.WIDTH(kss_pkg::DW), .DEPTH(kss_pkg::MAX_ELEMENTS)) u_store (
    .clk   (clk),
    .we    (cmd.accept && room),
    .waddr (count_r[kss_pkg::AW-1:0]),
    .wdata (in_element_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    stat.rank_bad = (in_rank == '0) || (in_rank > n_now);
    stat.scan_end = {1'b0, j_r} == (count_r - kss_pkg::CW'(1));
    stat.hit      = (lt_r < rank_r) && (rank_r <= le_r);
  end

  always_comb begin
    count_nxt = count_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    lt_nxt    = lt_r;
    le_nxt    = le_r;
    rank_nxt  = rank_r;
    cand_nxt  = cand_r;
    res_nxt   = res_r;
    err_nxt   = err_r;
    cmp_v_nxt = cmd.scan_rd;
    if (cmd.accept) begin
      count_nxt = n_now;
      if (in_last_item) begin
        rank_nxt = in_rank;
        i_nxt    = '0;
        res_nxt  = '0;
        err_nxt  = stat.rank_bad;
      end
    end
    if (cmd.cand_cap) begin
      cand_nxt = rdata;
      j_nxt    = '0;
      lt_nxt   = '0;
      le_nxt   = '0;
    end
    if (cmd.scan_rd) begin
      j_nxt = j_r + kss_pkg::AW'(1);
    end
    if (cmp_v_r) begin
      if (rdata < cand_r) begin
        lt_nxt = lt_r + kss_pkg::CW'(1);
      end
      if (rdata <= cand_r) begin
        le_nxt = le_r + kss_pkg::CW'(1);
      end
    end
    if (cmd.check) begin
      if (stat.hit) begin
        res_nxt = cand_r;
        err_nxt = 1'b0;
      end else begin
        i_nxt = i_r + kss_pkg::AW'(1);
      end
    end
    if (cmd.finish) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    lt_r   <= lt_nxt;
    le_r   <= le_nxt;
    rank_r <= rank_nxt;
    cand_r <= cand_nxt;
    res_r  <= res_nxt;
    err_r  <= err_nxt;
  end

  assign out_selected_value = res_r;
  assign out_rank_error     = err_r;
  assign count_o            = count_r;
endmodule
`default_nettype wire

@@ sv/kss_ctrl.sv @@
// ----------------------------------------------------------------------------
// kss_ctrl
// Sequencer for loading, candidate scans and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module kss_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_last_item,
  input  wire logic           out_stall,
  input  wire kss_pkg::stat_t stat,
  output kss_pkg::cmd_t       cmd,
  output logic                in_stall,
  output logic                out_valid,
  output kss_pkg::state_t     state_o
);
  kss_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kss_pkg::S_LOAD: begin
        if (in_valid && in_last_item) begin
          state_nxt = stat.rank_bad ? kss_pkg::S_OUT : kss_pkg::S_CAND;
        end
      end
      kss_pkg::S_CAND:  state_nxt = kss_pkg::S_CWAIT;
      kss_pkg::S_CWAIT: state_nxt = kss_pkg::S_SCAN;
      kss_pkg::S_SCAN: begin
        if (stat.scan_end) begin
          state_nxt = kss_pkg::S_DRAIN;
        end
      end
      kss_pkg::S_DRAIN: state_nxt = kss_pkg::S_CHECK;
      kss_pkg::S_CHECK: state_nxt = stat.hit ? kss_pkg::S_OUT : kss_pkg::S_CAND;
      kss_pkg::S_OUT: begin
        if (!out_stall) begin
          state_nxt = kss_pkg::S_LOAD;
        end
      end
      default: state_nxt = kss_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      kss_pkg::S_LOAD: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      kss_pkg::S_CAND:  cmd.cand_rd  = 1'b1;
      kss_pkg::S_CWAIT: cmd.cand_cap = 1'b1;
      kss_pkg::S_SCAN:  cmd.scan_rd  = 1'b1;
      kss_pkg::S_DRAIN: cmd = '0;
      kss_pkg::S_CHECK: cmd.check    = 1'b1;
      kss_pkg::S_OUT: begin
        out_valid  = 1'b1;
        cmd.finish = !out_stall;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kss_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state_o = state_r;
endmodule
`default_nettype wire
